// ===== hw/rtl/rau_pkg.sv =====
// Package for the rational arithmetic unit: action and status codes,
// sequencer states and the status struct between sequencer and divider.
// No dependencies.
`default_nettype none
package rau_pkg;
    typedef enum logic [2:0] {
        t_act_add = 3'd0,
        t_act_sub = 3'd1,
        t_act_mul = 3'd2,
        t_act_div = 3'd3,
        t_act_cmp = 3'd4
    } t_action;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef enum logic [3:0] {
        t_s_idle, t_s_mul0, t_s_mul1, t_s_mul2, t_s_sum,
        t_s_gcd, t_s_gcdw, t_s_q1, t_s_q1w, t_s_q2, t_s_q2w, t_s_fin, t_s_out
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
    } t_div_ctl;
endpackage
`default_nettype wire

// ===== hw/rtl/rau_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, 64-bit operands.
// Depends on rau_pkg.
`default_nettype none
module rau_div (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_start,
    input  wire [63:0]      i_dividend,
    input  wire [63:0]      i_divisor,
    output rau_pkg::t_div_ctl o_ctl,
    output logic [63:0]     o_quot,
    output logic [63:0]     o_rem
);
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [63:0] r_q;
    logic [63:0] r_r;
    logic [63:0] r_d;
    logic [64:0] w_trial;
    logic [64:0] w_diff;

    assign w_trial = {r_r, r_q[63]};
    assign w_diff  = w_trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'd64;
            r_q    <= i_dividend;
            r_r    <= '0;
            r_d    <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[64]) begin
                r_r <= w_diff[63:0];
                r_q <= {r_q[62:0], 1'b1};
            end else begin
                r_r <= w_trial[63:0];
                r_q <= {r_q[62:0], 1'b0};
            end
            r_cnt <= r_cnt - 7'd1;
            if (r_cnt == 7'd1) r_busy <= 1'b0;
        end
    end

    assign o_ctl.start = i_start;
    assign o_ctl.busy  = r_busy;
    assign o_quot = r_q;
    assign o_rem  = r_r;
endmodule
`default_nettype wire

// ===== hw/rtl/rational_arithmetic_unit.sv =====
// Rational arithmetic unit top level: sequencer, one shared 32x32
// multiplier step and the shared divider. Depends on rau_pkg, rau_div.
//
// Usage: an input transaction (i_valid/o_ready) carries an action and two
// rationals. A result transaction (o_valid/i_ready) returns the reduced
// quotient, an equality flag and a status. One item at a time: o_ready is
// high only while idle. The work runs through the multiplier states mul0,
// mul1 and mul2, a sum state, then the Euclidean loop. Each remainder
// step is a start state followed by a wait on the bit-serial divider.
// Two more divisions by the gcd then reduce numerator and denominator,
// followed by a final state. Errors and unused actions go from mul0
// straight to the output state, compare goes there from the sum state and
// a zero numerator from the first gcd state. The result is held in output
// registers until accepted; a stalled receiver simply holds the block in
// its output state, and the block is ready again in the cycle after the
// result transaction. Reset drops any work in flight and returns to idle
// with no result pending.
// Overflow and divide by zero are flagged in status with result 0/1.
`default_nettype none
module rational_arithmetic_unit #(
    parameter int WIDTH = 32
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire  [2:0]        i_action,
    input  wire signed [31:0] i_a_num,
    input  wire  [30:0]       i_a_den,
    input  wire signed [31:0] i_b_num,
    input  wire  [30:0]       i_b_den,
    output logic              o_valid,
    input  wire               i_ready,
    output logic signed [31:0] o_res_num,
    output logic [30:0]       o_res_den,
    output logic              o_is_equal,
    output logic [1:0]        o_status
);
    localparam logic [63:0] WMASK = (64'd1 << WIDTH) - 64'd1;
    localparam logic [63:0] DMASK = WMASK >> 1;

    rau_pkg::t_state r_state, n_state;
    logic        r_an, r_bn, r_rn;
    logic [31:0] r_am, r_bm, r_ad, r_bd;
    logic [2:0]  r_act;
    logic [63:0] r_p0, r_p1, r_p2, r_rm, r_rd, r_x, r_y, r_g;
    logic        r_eq;
    logic [1:0]  r_st;
    logic [31:0] r_o_num;
    logic [30:0] r_o_den;

    // shared multiplier
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod;
    assign w_prod = {32'd0, w_ma} * {32'd0, w_mb};

    logic        w_start;
    logic [63:0] w_dvd, w_dvs, w_quot, w_rem;
    rau_pkg::t_div_ctl w_dctl;

    rau_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_dividend(w_dvd), .i_divisor(w_dvs), .o_ctl(w_dctl),
        .o_quot(w_quot), .o_rem(w_rem)
    );

    // operand unpack
    logic [63:0] w_av, w_bv;
    logic        w_an, w_bn;
    assign w_av = {32'd0, i_a_num} & WMASK;
    assign w_bv = {32'd0, i_b_num} & WMASK;
    assign w_an = w_av[WIDTH-1];
    assign w_bn = w_bv[WIDTH-1];

    logic w_n2;
    assign w_n2 = (r_act == rau_pkg::t_act_sub) ? !r_bn : r_bn;

    // signed sum of the two cross products in sign-magnitude form
    logic        w_sum_neg;
    logic [63:0] w_sum_mag;
    assign w_sum_neg = (r_an == w_n2 || r_p0 >= r_p1) ? r_an : w_n2;
    assign w_sum_mag = (r_an == w_n2) ? r_p0 + r_p1 :
                       (r_p0 >= r_p1) ? r_p0 - r_p1 : r_p1 - r_p0;

    logic w_div_done;
    assign w_div_done = !w_dctl.busy && !w_dctl.start;

    always_comb begin
        n_state = r_state;
        w_start = 1'b0;
        w_dvd   = r_x;
        w_dvs   = r_y;
        w_ma    = r_am;
        w_mb    = r_bd;
        case (r_state)
            rau_pkg::t_s_idle: begin
                if (i_valid) n_state = rau_pkg::t_s_mul0;
            end
            rau_pkg::t_s_mul0: begin
                w_ma = r_am; w_mb = r_bd;
                // unused action, zero denominator or zero divisor: finish now
                if (r_act > rau_pkg::t_act_cmp || r_ad == 32'd0 || r_bd == 32'd0 ||
                    (r_act == rau_pkg::t_act_div && r_bm == 32'd0))
                    n_state = rau_pkg::t_s_out;
                else n_state = rau_pkg::t_s_mul1;
            end
            rau_pkg::t_s_mul1: begin
                w_ma = (r_act == rau_pkg::t_act_mul) ? r_am : r_bm;
                w_mb = (r_act == rau_pkg::t_act_mul) ? r_bm : r_ad;
                n_state = rau_pkg::t_s_mul2;
            end
            rau_pkg::t_s_mul2: begin
                w_ma = r_ad;
                w_mb = (r_act == rau_pkg::t_act_div) ? r_bm : r_bd;
                n_state = rau_pkg::t_s_sum;
            end
            rau_pkg::t_s_sum: begin
                n_state = (r_act == rau_pkg::t_act_cmp) ? rau_pkg::t_s_out
                                                        : rau_pkg::t_s_gcd;
            end
            rau_pkg::t_s_gcd: begin
                w_start = 1'b1;
                n_state = (r_rm == 64'd0) ? rau_pkg::t_s_out : rau_pkg::t_s_gcdw;
            end
            rau_pkg::t_s_gcdw: begin
                if (w_div_done)
                    n_state = (w_rem == 64'd0) ? rau_pkg::t_s_q1 : rau_pkg::t_s_gcd;
            end
            rau_pkg::t_s_q1: begin
                w_start = 1'b1; w_dvd = r_rm; w_dvs = r_g;
                n_state = rau_pkg::t_s_q1w;
            end
            rau_pkg::t_s_q1w: begin
                if (w_div_done) n_state = rau_pkg::t_s_q2;
            end
            rau_pkg::t_s_q2: begin
                w_start = 1'b1; w_dvd = r_rd; w_dvs = r_g;
                n_state = rau_pkg::t_s_q2w;
            end
            rau_pkg::t_s_q2w: begin
                if (w_div_done) n_state = rau_pkg::t_s_fin;
            end
            rau_pkg::t_s_fin: n_state = rau_pkg::t_s_out;
            rau_pkg::t_s_out: begin
                if (i_ready) n_state = rau_pkg::t_s_idle;
            end
            default: n_state = rau_pkg::t_s_idle;
        endcase
        o_ready = (r_state == rau_pkg::t_s_idle);
        o_valid = (r_state == rau_pkg::t_s_out);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::t_s_idle;
        end else begin
            r_state <= n_state;
            case (r_state)
                rau_pkg::t_s_idle: if (i_valid) begin
                    r_act <= i_action;
                    r_an  <= w_an;
                    r_bn  <= w_bn;
                    r_am  <= w_an ? 32'((~w_av + 64'd1) & WMASK) : w_av[31:0];
                    r_bm  <= w_bn ? 32'((~w_bv + 64'd1) & WMASK) : w_bv[31:0];
                    r_ad  <= 32'({33'd0, i_a_den} & DMASK);
                    r_bd  <= 32'({33'd0, i_b_den} & DMASK);
                end
                rau_pkg::t_s_mul0: begin
                    r_p0 <= w_prod;
                    r_o_num <= '0; r_o_den <= 31'd1; r_eq <= 1'b0;
                    r_st <= rau_pkg::ST_OK;
                    if (r_act > rau_pkg::t_act_cmp) r_st <= rau_pkg::ST_OK;
                    else if (r_ad == 32'd0 || r_bd == 32'd0) r_st <= rau_pkg::ST_DIVZ;
                    else if (r_act == rau_pkg::t_act_div && r_bm == 32'd0)
                        r_st <= rau_pkg::ST_DIVZ;
                end
                rau_pkg::t_s_mul1: r_p1 <= w_prod;
                rau_pkg::t_s_mul2: r_p2 <= w_prod;
                rau_pkg::t_s_sum: begin
                    r_rd <= r_p2;
                    r_y  <= r_p2;
                    case (r_act)
                        rau_pkg::t_act_add, rau_pkg::t_act_sub: begin
                            r_rn <= w_sum_neg; r_rm <= w_sum_mag; r_x <= w_sum_mag;
                        end
                        rau_pkg::t_act_mul: begin
                            r_rn <= r_an ^ r_bn; r_rm <= r_p1; r_x <= r_p1;
                        end
                        rau_pkg::t_act_div: begin
                            r_rn <= r_an ^ r_bn; r_rm <= r_p0; r_x <= r_p0;
                        end
                        default: begin
                            r_eq <= (r_p0 == r_p1) && (r_p0 == 64'd0 || r_an == r_bn);
                        end
                    endcase
                end
                rau_pkg::t_s_gcdw: if (w_div_done) begin
                    // advance the Euclid pair; the last nonzero divisor is the gcd
                    r_x <= r_y;
                    r_y <= w_rem;
                    if (w_rem == 64'd0) r_g <= r_y;
                end
                rau_pkg::t_s_q1w: if (w_div_done) r_rm <= w_quot;
                rau_pkg::t_s_q2w: if (w_div_done) r_rd <= w_quot;
                rau_pkg::t_s_fin: begin
                    if (r_rm > DMASK || r_rd > DMASK) r_st <= rau_pkg::ST_OVF;
                    else begin
                        r_o_num <= r_rn ? 32'(64'd0 - r_rm) : r_rm[31:0];
                        r_o_den <= r_rd[30:0];
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_res_num  = r_o_num;
    assign o_res_den  = r_o_den;
    assign o_is_equal = r_eq;
    assign o_status   = r_st;
endmodule
`default_nettype wire

// ===== hw/rtl/rau_checker.sv =====
// Port-level checker for the rational arithmetic unit, bound to the top.
// Depends on rau_pkg and rational_arithmetic_unit.
`default_nettype none
module rau_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_ready,
    input wire        o_valid,
    input wire        i_ready,
    input wire [30:0] o_res_den,
    input wire [31:0] o_res_num,
    input wire        o_is_equal,
    input wire [1:0]  o_status
);
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res_num))
        else $error("result dropped");
    a_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_res_den != 31'd0) else $error("zero denominator");
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != rau_pkg::ST_OK |-> o_res_num == 32'd0 && !o_is_equal)
        else $error("error result not zero");
endmodule

bind rational_arithmetic_unit rau_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready), .o_valid(o_valid),
    .i_ready(i_ready), .o_res_den(o_res_den), .o_res_num(o_res_num),
    .o_is_equal(o_is_equal), .o_status(o_status)
);
`default_nettype wire
